FILE: hdl/ssd_pkg.sv
// shared types, constants and digit encoding for the seven-segment command sequencer
package ssd_pkg;

  localparam int MAX_DIGITS = 4;
  localparam int SEG_N      = (MAX_DIGITS > 4) ? MAX_DIGITS : 4;
  localparam int SEG_IW     = (SEG_N > 1) ? $clog2(SEG_N) : 1;
  localparam int CNT_W      = $clog2(SEG_N + 1);
  localparam int CNT_LIM    = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
  localparam int VB_W       = 8 * SEG_N;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam int REP_W   = 2;

  localparam logic [7:0] CMD_AUTO  = 8'h40;
  localparam logic [7:0] CMD_FIXED = 8'h44;
  localparam logic [7:0] ADDR_BASE = 8'hc0;
  localparam logic [7:0] CTRL_ON   = 8'h88;
  localparam logic [7:0] BLANK_IN  = 8'h7f;
  localparam logic [7:0] DASH_IN   = 8'h40;
  localparam logic [7:0] POINT_BIT = 8'h80;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic [REP_W-1:0] REP_ONE   = 2'd0;
  localparam logic [REP_W-1:0] REP_CLEAR = 2'd3;

  localparam logic [2:0] DIGIT_COUNT_RST = 3'd4;
  localparam logic [2:0] BRIGHTNESS_RST  = 3'd2;

  typedef enum logic [1:0] {
    CMD_SHOW_ALL = 2'd0,
    CMD_SHOW_ONE = 2'd1,
    CMD_RAW      = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_COUNT = 1'd0,
    REG_BRIGHTNESS  = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DCMD,
    ST_ADDR,
    ST_DATA,
    ST_CTRL
  } bk_state_t;

  typedef logic [CNT_W-1:0] cnt_t;

  // one decoded request
  typedef struct packed {
    logic                  auto_inc;
    cnt_t                  cnt;
    logic [2:0]            addr;
    logic [REP_W-1:0]      rep_max;
    logic [SEG_N-1:0][7:0] seg;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'h3f;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5b;
      4'h3: g = 8'h4f;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6d;
      4'h6: g = 8'h7d;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7f;
      4'h9: g = 8'h6f;
      4'ha: g = 8'h77;
      4'hb: g = 8'h7c;
      4'hc: g = 8'h39;
      4'hd: g = 8'h5e;
      4'he: g = 8'h79;
      4'hf: g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] encode_digit(input logic [7:0] v);
    logic [7:0] s;
    if (v == BLANK_IN) begin
      s = SEG_BLANK;
    end else if (v == DASH_IN) begin
      s = DASH_IN;
    end else if (v > BLANK_IN) begin
      s = glyph(v[3:0]) | POINT_BIT;
    end else begin
      s = glyph(v[3:0]);
    end
    return s;
  endfunction

endpackage

FILE: hdl/seven_segment_display_command_sequencer.sv
// top level: config registers, classifier, descriptor queue and byte sequencer
//
//  channel   dir  handshake            payload
//  in_       in   in_tvalid/in_tready  tuser cmd, tdata position and four digit values
//  out_      out  out_tvalid/out_tready tdata tx_byte, tuser frame flags, tlast
//  cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
//  a request is taken whenever the two-entry queue has room
//  the sequencer sends one byte per cycle through its output register unless out_tready
//  stalls it; a request sends a data command, an address, its data bytes and a control
//  byte, repeated for digits 0 to 3 on clear all; that byte loop sets the sustained rate
//  reset clears the queue, the sequencer and the registers (digit count 4, brightness 2)
//  a stalled output holds its byte while the queue keeps accepting requests
module seven_segment_display_command_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] position, [10:3] value_0, [18:11] value_1, [26:19] value_2,
  // [34:27] value_3, [39:35] zero
  input  logic [ssd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [ssd_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] tx_byte
  output logic [ssd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] opens_frame, [1] closes_frame
  output logic [ssd_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [2:0]          digit_count_r, digit_count_nxt;
  logic [2:0]          brightness_r, brightness_nxt;
  logic                push, pop;
  ssd_pkg::desc_t      push_desc, head_desc;
  ssd_pkg::q_stat_t    q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    digit_count_nxt = digit_count_r;
    brightness_nxt  = brightness_r;
    if (cfg_valid && cfg_ready) begin
      case (ssd_pkg::reg_idx_t'(cfg_index))
        ssd_pkg::REG_DIGIT_COUNT: digit_count_nxt = cfg_data;
        ssd_pkg::REG_BRIGHTNESS:  brightness_nxt  = cfg_data;
        default: begin
          digit_count_nxt = digit_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= ssd_pkg::DIGIT_COUNT_RST;
      brightness_r  <= ssd_pkg::BRIGHTNESS_RST;
    end else begin
      digit_count_r <= digit_count_nxt;
      brightness_r  <= brightness_nxt;
    end
  end

  ssd_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .digit_count (digit_count_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_desc   (push_desc)
  );

  ssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .q_stat    (q_stat)
  );

  ssd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_desc  (head_desc),
    .q_stat     (q_stat),
    .pop        (pop),
    .brightness (brightness_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/ssd_front.sv
// request classifier: decodes a request into a frame descriptor
module ssd_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ssd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [ssd_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic [2:0]                         digit_count,
  input  ssd_pkg::q_stat_t                   q_stat,
  output logic                               push,
  output ssd_pkg::desc_t                     push_desc
);

  logic [2:0]                                 pos;
  logic [ssd_pkg::VB_W-1:0]                   vbits;
  logic [ssd_pkg::SEG_N-1:0][7:0]             vals;
  ssd_pkg::cmd_t                              cmd;
  ssd_pkg::cnt_t                              show_cnt;

  assign cmd       = ssd_pkg::cmd_t'(in_tuser);
  assign pos       = in_tdata[2:0];
  assign vbits     = ssd_pkg::VB_W'(in_tdata[34:3]);
  assign vals      = vbits;
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    if (digit_count > 3'(ssd_pkg::CNT_LIM)) begin
      show_cnt = ssd_pkg::CNT_W'(ssd_pkg::CNT_LIM);
    end else begin
      show_cnt = ssd_pkg::CNT_W'(digit_count);
    end
  end

  always_comb begin
    push_desc          = '0;
    push_desc.rep_max  = ssd_pkg::REP_ONE;
    case (cmd)
      ssd_pkg::CMD_SHOW_ALL: begin
        push_desc.auto_inc = 1'b1;
        push_desc.cnt      = show_cnt;
        for (int i = 0; i < ssd_pkg::SEG_N; i++) begin
          push_desc.seg[i] = ssd_pkg::encode_digit(vals[i]);
        end
      end
      ssd_pkg::CMD_SHOW_ONE: begin
        push_desc.addr   = pos;
        push_desc.seg[0] = ssd_pkg::encode_digit(vals[0]);
      end
      ssd_pkg::CMD_RAW: begin
        if (pos == 3'd0) begin
          push_desc.auto_inc = 1'b1;
          push_desc.cnt      = ssd_pkg::CNT_W'(ssd_pkg::MAX_DIGITS);
          for (int i = 0; i < ssd_pkg::SEG_N; i++) begin
            push_desc.seg[i] = vals[0];
          end
        end else begin
          push_desc.addr   = pos - 3'd1;
          push_desc.seg[0] = vals[0];
        end
      end
      ssd_pkg::CMD_CLEAR: begin
        push_desc.seg[0] = ssd_pkg::SEG_BLANK;
        if (pos == 3'd0) begin
          // four fixed-address updates, digits 0 to 3
          push_desc.rep_max = ssd_pkg::REP_CLEAR;
        end else begin
          push_desc.addr = pos - 3'd1;
        end
      end
      default: begin
        push_desc = '0;
      end
    endcase
  end

endmodule

FILE: hdl/ssd_queue.sv
// two-entry descriptor queue between classifier and byte sequencer
module ssd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssd_pkg::desc_t     push_desc,
  input  logic               pop,
  output ssd_pkg::desc_t     head_desc,
  output ssd_pkg::q_stat_t   q_stat
);

  ssd_pkg::desc_t              mem_r [ssd_pkg::Q_DEPTH];
  logic [ssd_pkg::Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ssd_pkg::Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ssd_pkg::Q_CW-1:0]    count_r, count_nxt;

  assign q_stat.full  = (count_r == ssd_pkg::Q_CW'(ssd_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_desc    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

endmodule

FILE: hdl/ssd_back.sv
// byte sequencer: walks a descriptor through its frames, one byte per cycle while the output is not stalled
module ssd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssd_pkg::desc_t                     head_desc,
  input  ssd_pkg::q_stat_t                   q_stat,
  output logic                               pop,
  input  logic [2:0]                         brightness,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ssd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [ssd_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  ssd_pkg::bk_state_t                state_r, state_nxt;
  ssd_pkg::desc_t                    desc_r;
  logic [ssd_pkg::SEG_IW-1:0]        seg_idx_r, seg_idx_nxt;
  logic [ssd_pkg::REP_W-1:0]         rep_r, rep_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic [7:0]                        obyte_r;
  logic                              oopen_r, oclose_r, olast_r;

  logic                              adv;
  logic                              seg_end;
  logic                              more_reps;
  logic                              done;
  logic [7:0]                        byte_c;
  logic                              open_c, close_c, last_c;

  assign adv       = (state_r != ssd_pkg::ST_IDLE) && (!ovalid_r || out_tready);
  assign seg_end   = (ssd_pkg::cnt_t'(seg_idx_r) + ssd_pkg::cnt_t'(1)) == desc_r.cnt;
  assign more_reps = !desc_r.auto_inc && (rep_r != desc_r.rep_max);
  assign done      = (state_r == ssd_pkg::ST_CTRL) && adv && !more_reps;
  assign pop       = ((state_r == ssd_pkg::ST_IDLE) || done) && !q_stat.empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssd_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ssd_pkg::ST_DCMD;
        end
      end
      ssd_pkg::ST_DCMD: begin
        if (adv) begin
          state_nxt = ssd_pkg::ST_ADDR;
        end
      end
      ssd_pkg::ST_ADDR: begin
        if (adv) begin
          if (desc_r.auto_inc && desc_r.cnt == '0) begin
            state_nxt = ssd_pkg::ST_CTRL;
          end else begin
            state_nxt = ssd_pkg::ST_DATA;
          end
        end
      end
      ssd_pkg::ST_DATA: begin
        if (adv && (!desc_r.auto_inc || seg_end)) begin
          state_nxt = ssd_pkg::ST_CTRL;
        end
      end
      ssd_pkg::ST_CTRL: begin
        if (adv) begin
          if (more_reps || !q_stat.empty) begin
            state_nxt = ssd_pkg::ST_DCMD;
          end else begin
            state_nxt = ssd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ssd_pkg::ST_IDLE;
      end
    endcase
  end

  // byte and framing flags for the current step
  always_comb begin
    byte_c  = '0;
    open_c  = 1'b0;
    close_c = 1'b0;
    last_c  = 1'b0;
    case (state_r)
      ssd_pkg::ST_IDLE: begin
        byte_c = '0;
      end
      ssd_pkg::ST_DCMD: begin
        byte_c  = desc_r.auto_inc ? ssd_pkg::CMD_AUTO : ssd_pkg::CMD_FIXED;
        open_c  = 1'b1;
        close_c = 1'b1;
      end
      ssd_pkg::ST_ADDR: begin
        byte_c  = ssd_pkg::ADDR_BASE | {5'd0, desc_r.addr + {1'b0, rep_r}};
        open_c  = 1'b1;
        close_c = desc_r.auto_inc && (desc_r.cnt == '0);
      end
      ssd_pkg::ST_DATA: begin
        byte_c  = desc_r.seg[seg_idx_r];
        close_c = !desc_r.auto_inc || seg_end;
      end
      ssd_pkg::ST_CTRL: begin
        byte_c  = ssd_pkg::CTRL_ON + {5'd0, brightness};
        open_c  = 1'b1;
        close_c = 1'b1;
        last_c  = !more_reps;
      end
      default: begin
        byte_c = '0;
      end
    endcase
  end

  always_comb begin
    seg_idx_nxt = seg_idx_r;
    rep_nxt     = rep_r;
    if (pop) begin
      seg_idx_nxt = '0;
      rep_nxt     = '0;
    end else if (adv && state_r == ssd_pkg::ST_DATA && desc_r.auto_inc && !seg_end) begin
      seg_idx_nxt = seg_idx_r + 1'b1;
    end else if (adv && state_r == ssd_pkg::ST_CTRL && more_reps) begin
      rep_nxt = rep_r + 1'b1;
    end
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ssd_pkg::ST_IDLE;
      seg_idx_r <= '0;
      rep_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seg_idx_r <= seg_idx_nxt;
      rep_r     <= rep_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= head_desc;
    end
    if (adv) begin
      obyte_r  <= byte_c;
      oopen_r  <= open_c;
      oclose_r <= close_c;
      olast_r  <= last_c;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = {oclose_r, oopen_r};
  assign out_tlast  = olast_r;

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssd_pkg::ST_DATA && desc_r.auto_inc)
      |-> (ssd_pkg::cnt_t'(seg_idx_r) < desc_r.cnt))
    else $error("segment index past digit count");

  a_rep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ssd_pkg::ST_IDLE && !desc_r.auto_inc) |-> (rep_r <= desc_r.rep_max))
    else $error("repeat count past its limit");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && olast_r) |-> (oclose_r && oopen_r))
    else $error("final byte of a request is not a closed control frame");

endmodule
